FILE: hdl/lspd_pkg.sv
// ----------------------------------------------------------------------------
// lspd_pkg
// Shared types and constants of the plaquette string detector.
// ----------------------------------------------------------------------------
package lspd_pkg;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 11;
    localparam int SIDE_BITS      = 7;
    localparam int DEPTH_BITS     = 11;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SIDE_LENGTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEPTH_PLANES = 1'b1;

    localparam int SIDE_RESET_VALUE  = 64;
    localparam int DEPTH_RESET_VALUE = 64;
    localparam int SIDE_MIN          = 2;
    localparam int DEPTH_MIN         = 1;

    localparam int KIND_BITS   = 2;
    localparam int ANCHOR_BITS = 6;
    localparam int ZANCH_BITS  = 10;
    localparam int COUNT_BITS  = 24;

    localparam logic [KIND_BITS-1:0] KIND_XY      = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_YZ      = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_XZ      = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_INVALID = 2'd3;

    localparam logic signed [3:0] WIND_POS = 4'sd2;
    localparam logic signed [3:0] WIND_NEG = -4'sd2;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [ANCHOR_BITS-1:0] xm1;
        logic [ANCHOR_BITS-1:0] x0;
        logic [ANCHOR_BITS-1:0] ym1;
        logic [ANCHOR_BITS-1:0] y0;
        logic [ZANCH_BITS-1:0]  p0;
        logic [ZANCH_BITS-1:0]  pm1;
    } lspd_pos_t;

    typedef struct packed {
        logic [2:0]            hits;
        logic [2:0]            neg;
        lspd_pos_t             pos;
        logic [COUNT_BITS-1:0] base;
    } lspd_entry_t;

endpackage

FILE: hdl/lspd_sample_if.sv
// ----------------------------------------------------------------------------
// lspd_sample_if
// Field sample channel: valid, ready and one complex sample.
// ----------------------------------------------------------------------------
interface lspd_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_real;
    logic signed [SAMPLE_BITS-1:0] sample_imag;

    modport source (output valid, output sample_real, output sample_imag, input ready);
    modport sink   (input valid, input sample_real, input sample_imag, output ready);
endinterface

FILE: hdl/lspd_hit_if.sv
// ----------------------------------------------------------------------------
// lspd_hit_if
// String hit channel: valid, ready and one hit report.
// ----------------------------------------------------------------------------
interface lspd_hit_if;
    logic                                valid;
    logic                                ready;
    logic [lspd_pkg::KIND_BITS-1:0]      plaquette_kind;
    logic [lspd_pkg::ANCHOR_BITS-1:0]    anchor_x;
    logic [lspd_pkg::ANCHOR_BITS-1:0]    anchor_y;
    logic [lspd_pkg::ZANCH_BITS-1:0]     anchor_z;
    logic                                winding_negative;
    logic [lspd_pkg::COUNT_BITS-1:0]     strings_found;
    logic                                last_of_run;

    modport source (
        output valid, output plaquette_kind, output anchor_x, output anchor_y,
        output anchor_z, output winding_negative, output strings_found,
        output last_of_run, input ready
    );
    modport sink (
        input valid, input plaquette_kind, input anchor_x, input anchor_y,
        input anchor_z, input winding_negative, input strings_found,
        input last_of_run, output ready
    );
endinterface

FILE: hdl/lattice_string_plaquette_detector.sv
// ----------------------------------------------------------------------------
// lattice_string_plaquette_detector
// Streams a complex field volume and reports plaquettes that carry a string.
// ----------------------------------------------------------------------------
// usage
// - sample_in: one complex sample per transfer, raster order, x fastest,
//   side_length^2 * (depth_planes + 1) samples per volume
// - hit_out: one transfer per string plaquette, kinds in order xy, yz, xz,
//   last_of_run marks the final hit of one sample
// - cfg: write side_length (index 0) or depth_planes (index 1) while idle,
//   a write restarts the volume
// - path: a hit passes the front pipeline registers, the queue and the output register
// - throughput: one sample per cycle while sample_in.ready is high; a sample
//   with k hits gives k hit transfers through the single output register
// - a four-entry queue parts front and back; when it fills, sample_in.ready
//   drops until the receiver drains hits
// - reset clears position and hit counters, side_length and depth_planes
//   return to 64; the plane and row buffers fill as the first plane streams
// ----------------------------------------------------------------------------
module lattice_string_plaquette_detector #(
    parameter int MAX_SIDE    = 64,
    parameter int MAX_DEPTH   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lspd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lspd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    lspd_sample_if.sink                         sample_in,
    lspd_hit_if.source                          hit_out
);
    import lspd_pkg::*;

    logic        push, q_full, pop, head_valid;
    lspd_entry_t push_entry, head;

    lspd_front #(
        .MAX_SIDE(MAX_SIDE), .MAX_DEPTH(MAX_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .sample_in(sample_in), .q_full(q_full),
        .push(push), .entry(push_entry)
    );

    lspd_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_entry(push_entry),
        .pop(pop), .full(q_full), .head_valid(head_valid), .head(head)
    );

    lspd_back u_back (
        .clk(clk), .rst_n(rst_n), .head_valid(head_valid), .head(head),
        .pop(pop), .hit_out(hit_out)
    );

endmodule

FILE: hdl/lspd_ram.sv
// ----------------------------------------------------------------------------
// lspd_ram
// Generic single-write, single-read RAM with registered read-first output.
// ----------------------------------------------------------------------------
module lspd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

FILE: hdl/lspd_front.sv
// ----------------------------------------------------------------------------
// lspd_front
// Position tracking, line and plane delay buffers, plaquette winding test.
// ----------------------------------------------------------------------------
module lspd_front #(
    parameter int MAX_SIDE    = 64,
    parameter int MAX_DEPTH   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [lspd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [lspd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    lspd_sample_if.sink                          sample_in,
    input  logic                                 q_full,
    output logic                                 push,
    output lspd_pkg::lspd_entry_t                entry
);
    import lspd_pkg::*;

    localparam int XW    = $clog2(MAX_SIDE);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int DW    = $clog2(MAX_DEPTH + 1);
    localparam int PLANE = MAX_SIDE * MAX_SIDE;
    localparam int PAW   = $clog2(PLANE);
    localparam int SQW   = $clog2(PLANE + 1);
    localparam int PW    = 2 * SAMPLE_BITS;
    localparam int SIDE_RST  = (SIDE_RESET_VALUE < MAX_SIDE) ? SIDE_RESET_VALUE : MAX_SIDE;
    localparam int DEPTH_RST = (DEPTH_RESET_VALUE < MAX_DEPTH) ? DEPTH_RESET_VALUE : MAX_DEPTH;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
    } cplx_t;

    logic [SW-1:0]  side_reg;
    logic [SQW-1:0] sq_reg;
    logic [DW-1:0]  depth_reg;
    logic [SW-1:0]  side_new;
    logic [SQW-1:0] sq_new;
    logic [DW-1:0]  depth_new;

    logic [XW-1:0]  x_reg, y_reg, x_next, y_next;
    logic [DW-1:0]  p_reg, p_next;
    logic [XW-1:0]  ptr_row_reg, ptr_c_reg;
    logic [PAW-1:0] ptr_pl_reg;

    logic           adv, accept, c_event;
    logic [SW:0]    xe, ye, le;
    logic           x_last, y_last, p_last;
    logic [2:0]     flg_in;
    lspd_pos_t      pos_in;
    cplx_t          cur_in;

    logic           v1_reg, v2_reg, v3_reg;
    cplx_t          cur1_reg, cur2_reg;
    logic [2:0]     flg1_reg, flg2_reg, flg3_reg;
    lspd_pos_t      pos1_reg, pos2_reg, pos3_reg;
    logic           ve1_reg, ve2_reg, ve3_reg;
    cplx_t          row2_reg, pl2_reg;
    cplx_t          prev_cur_reg, prev_row_reg, prev_pl_reg;

    cplx_t          pl_rd, row_rd, plsl_rd;

    cplx_t                   corner [3][4];
    logic signed [PW-1:0]    m1 [3][4];
    logic signed [PW-1:0]    m2 [3][4];
    logic [2:0][3:0]         crs;
    logic signed [PW-1:0]    m1_reg [3][4];
    logic signed [PW-1:0]    m2_reg [3][4];
    logic [2:0][3:0]         crs_reg;

    logic [2:0]              hit, neg, hits;
    logic [COUNT_BITS-1:0]   cnt_reg;

    assign adv             = !q_full;
    assign sample_in.ready = adv;
    assign accept          = sample_in.valid && adv;
    assign c_event         = v1_reg && adv;
    assign cur_in.re       = sample_in.sample_real;
    assign cur_in.im       = sample_in.sample_imag;

    // register write value clamping
    always_comb
    begin
        int unsigned sv;
        int unsigned dv;
        sv = 32'(cfg_data[SIDE_BITS-1:0]);
        dv = 32'(cfg_data[DEPTH_BITS-1:0]);
        if (sv < SIDE_MIN) sv = SIDE_MIN;
        if (sv > MAX_SIDE) sv = MAX_SIDE;
        if (dv < DEPTH_MIN) dv = DEPTH_MIN;
        if (dv > MAX_DEPTH) dv = MAX_DEPTH;
        side_new  = SW'(sv);
        sq_new    = SQW'(sv * sv);
        depth_new = DW'(dv);
    end

    // classify the arriving sample
    always_comb
    begin
        xe     = (SW+1)'(x_reg);
        ye     = (SW+1)'(y_reg);
        le     = (SW+1)'(side_reg);
        x_last = (xe + 1'b1) == le;
        y_last = (ye + 1'b1) == le;
        p_last = p_reg == depth_reg;
        flg_in[0] = (x_reg != '0) && (y_reg != '0) && (p_reg < depth_reg);
        flg_in[1] = (y_reg != '0) && (p_reg != '0) && ((xe + 2'd2) <= le);
        flg_in[2] = (x_reg != '0) && (p_reg != '0) && ((ye + 2'd2) <= le);
        pos_in.xm1 = ANCHOR_BITS'(x_reg - 1'b1);
        pos_in.x0  = ANCHOR_BITS'(x_reg);
        pos_in.ym1 = ANCHOR_BITS'(y_reg - 1'b1);
        pos_in.y0  = ANCHOR_BITS'(y_reg);
        pos_in.p0  = ZANCH_BITS'(p_reg);
        pos_in.pm1 = ZANCH_BITS'(p_reg - 1'b1);
        x_next = x_reg;
        y_next = y_reg;
        p_next = p_reg;
        if (!x_last)
        begin
            x_next = x_reg + 1'b1;
        end
        else
        begin
            x_next = '0;
            if (!y_last)
            begin
                y_next = y_reg + 1'b1;
            end
            else
            begin
                y_next = '0;
                p_next = p_last ? '0 : p_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg    <= SW'(SIDE_RST);
            sq_reg      <= SQW'(SIDE_RST * SIDE_RST);
            depth_reg   <= DW'(DEPTH_RST);
            x_reg       <= '0;
            y_reg       <= '0;
            p_reg       <= '0;
            ptr_row_reg <= '0;
            ptr_pl_reg  <= '0;
            ptr_c_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SIDE_LENGTH:
                begin
                    side_reg <= side_new;
                    sq_reg   <= sq_new;
                end
                REG_DEPTH_PLANES:
                begin
                    depth_reg <= depth_new;
                end
            endcase
            x_reg       <= '0;
            y_reg       <= '0;
            p_reg       <= '0;
            ptr_row_reg <= '0;
            ptr_pl_reg  <= '0;
            ptr_c_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                x_reg       <= x_next;
                y_reg       <= y_next;
                p_reg       <= p_next;
                ptr_row_reg <= (ptr_row_reg == XW'(side_reg - 1'b1)) ? '0 : ptr_row_reg + 1'b1;
                ptr_pl_reg  <= (ptr_pl_reg == PAW'(sq_reg - 1'b1)) ? '0 : ptr_pl_reg + 1'b1;
            end
            if (c_event)
            begin
                ptr_c_reg <= (ptr_c_reg == XW'(side_reg - 1'b1)) ? '0 : ptr_c_reg + 1'b1;
            end
        end
    end

    // delay buffers: one plane, one row, and one row behind the plane
    lspd_ram #(.WIDTH(PW), .DEPTH(PLANE)) u_plane_buf (
        .clk(clk), .we(accept), .waddr(ptr_pl_reg), .wdata(cur_in),
        .re(accept), .raddr(ptr_pl_reg), .rdata(pl_rd)
    );

    lspd_ram #(.WIDTH(PW), .DEPTH(MAX_SIDE)) u_row_buf (
        .clk(clk), .we(accept), .waddr(ptr_row_reg), .wdata(cur_in),
        .re(accept), .raddr(ptr_row_reg), .rdata(row_rd)
    );

    lspd_ram #(.WIDTH(PW), .DEPTH(MAX_SIDE)) u_lag_buf (
        .clk(clk), .we(c_event), .waddr(ptr_c_reg), .wdata(pl_rd),
        .re(c_event), .raddr(ptr_c_reg), .rdata(plsl_rd)
    );

    // corner selection and cross products
    always_comb
    begin
        corner[0][0] = prev_row_reg;
        corner[0][1] = row2_reg;
        corner[0][2] = cur2_reg;
        corner[0][3] = prev_cur_reg;
        corner[1][0] = plsl_rd;
        corner[1][1] = pl2_reg;
        corner[1][2] = cur2_reg;
        corner[1][3] = row2_reg;
        corner[2][0] = prev_pl_reg;
        corner[2][1] = prev_cur_reg;
        corner[2][2] = cur2_reg;
        corner[2][3] = pl2_reg;
        for (int k = 0; k < 3; k++)
        begin
            for (int e = 0; e < 4; e++)
            begin
                m1[k][e]  = corner[k][e].im * corner[k][(e + 1) & 3].re;
                m2[k][e]  = corner[k][e].re * corner[k][(e + 1) & 3].im;
                crs[k][e] = (corner[k][e].im > 0) != (corner[k][(e + 1) & 3].im > 0);
            end
        end
    end

    // winding sums
    always_comb
    begin
        logic signed [3:0] sum;
        for (int k = 0; k < 3; k++)
        begin
            sum = '0;
            for (int e = 0; e < 4; e++)
            begin
                if (crs_reg[k][e])
                begin
                    sum = (m1_reg[k][e] > m2_reg[k][e]) ? sum + 4'sd1 : sum - 4'sd1;
                end
            end
            hit[k] = (sum == WIND_POS) || (sum == WIND_NEG);
            neg[k] = sum[3];
        end
    end

    assign hits       = flg3_reg & hit;
    assign push       = v3_reg && adv && (hits != '0);
    assign entry.hits = hits;
    assign entry.neg  = neg;
    assign entry.pos  = pos3_reg;
    assign entry.base = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else if (cfg_we)
        begin
            cnt_reg <= '0;
        end
        else if (adv)
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (v3_reg)
            begin
                cnt_reg <= ve3_reg ? '0 : cnt_reg + COUNT_BITS'($countones(hits));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cur1_reg <= cur_in;
            flg1_reg <= flg_in;
            pos1_reg <= pos_in;
            ve1_reg  <= x_last && y_last && p_last;
            cur2_reg <= cur1_reg;
            row2_reg <= row_rd;
            pl2_reg  <= pl_rd;
            flg2_reg <= flg1_reg;
            pos2_reg <= pos1_reg;
            ve2_reg  <= ve1_reg;
            m1_reg   <= m1;
            m2_reg   <= m2;
            crs_reg  <= crs;
            flg3_reg <= flg2_reg;
            pos3_reg <= pos2_reg;
            ve3_reg  <= ve2_reg;
            if (v2_reg)
            begin
                prev_cur_reg <= cur2_reg;
                prev_row_reg <= row2_reg;
                prev_pl_reg  <= pl2_reg;
            end
        end
    end

endmodule

FILE: hdl/lspd_queue.sv
// ----------------------------------------------------------------------------
// lspd_queue
// Short register queue of hit entries between front and back.
// ----------------------------------------------------------------------------
module lspd_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lspd_pkg::lspd_entry_t push_entry,
    input  logic                  pop,
    output logic                  full,
    output logic                  head_valid,
    output lspd_pkg::lspd_entry_t head
);
    import lspd_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    lspd_entry_t     slot_reg [QUEUE_DEPTH];
    logic [AW-1:0]   wr_reg, rd_reg;
    logic [AW:0]     cnt_reg;

    assign full       = cnt_reg == (AW+1)'(QUEUE_DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head       = slot_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_entry;
        end
    end

endmodule

FILE: hdl/lspd_back.sv
// ----------------------------------------------------------------------------
// lspd_back
// Splits each queued entry into hit reports behind an output register.
// ----------------------------------------------------------------------------
module lspd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  lspd_pkg::lspd_entry_t head,
    output logic                  pop,
    lspd_hit_if.source            hit_out
);
    import lspd_pkg::*;

    logic [2:0]             done_reg;
    logic [2:0]             pending, pick;
    logic                   last, load;
    logic                   o_valid_reg;
    logic [KIND_BITS-1:0]   kind_reg, kind_next;
    logic [ANCHOR_BITS-1:0] ax_reg, ay_reg, ax_next, ay_next;
    logic [ZANCH_BITS-1:0]  az_reg, az_next;
    logic                   neg_reg, last_reg;
    logic [COUNT_BITS-1:0]  count_reg;

    assign pending = head.hits & ~done_reg;
    assign pick    = pending & (~pending + 3'd1);
    assign last    = (pending & ~pick) == '0;
    assign load    = head_valid && (!o_valid_reg || hit_out.ready);
    assign pop     = load && last;

    always_comb
    begin
        priority if (pick[0])
        begin
            kind_next = KIND_XY;
            ax_next   = head.pos.xm1;
            ay_next   = head.pos.ym1;
            az_next   = head.pos.p0;
        end
        else if (pick[1])
        begin
            kind_next = KIND_YZ;
            ax_next   = head.pos.x0;
            ay_next   = head.pos.ym1;
            az_next   = head.pos.pm1;
        end
        else
        begin
            kind_next = KIND_XZ;
            ax_next   = head.pos.xm1;
            ay_next   = head.pos.y0;
            az_next   = head.pos.pm1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
            done_reg    <= '0;
        end
        else
        begin
            if (load)
            begin
                o_valid_reg <= 1'b1;
                done_reg    <= last ? 3'b000 : (done_reg | pick);
            end
            else if (hit_out.ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= kind_next;
            ax_reg    <= ax_next;
            ay_reg    <= ay_next;
            az_reg    <= az_next;
            neg_reg   <= |(head.neg & pick);
            last_reg  <= last;
            count_reg <= head.base + COUNT_BITS'($countones(done_reg)) + 1'b1;
        end
    end

    assign hit_out.valid            = o_valid_reg;
    assign hit_out.plaquette_kind   = kind_reg;
    assign hit_out.anchor_x         = ax_reg;
    assign hit_out.anchor_y         = ay_reg;
    assign hit_out.anchor_z         = az_reg;
    assign hit_out.winding_negative = neg_reg;
    assign hit_out.strings_found    = count_reg;
    assign hit_out.last_of_run      = last_reg;

endmodule

FILE: hdl/lspd_checker.sv
// ----------------------------------------------------------------------------
// lspd_checker
// Port-level checks on the hit channel of the detector.
// ----------------------------------------------------------------------------
module lspd_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [lspd_pkg::KIND_BITS-1:0]      kind,
    input logic [lspd_pkg::COUNT_BITS-1:0]     strings_found,
    input logic                                last_of_run
);
    import lspd_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("hit valid dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(strings_found) && $stable(kind))
        else $error("hit payload changed while stalled");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind != KIND_INVALID)
        else $error("invalid plaquette kind");

    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid)
        else $error("gap inside a run of hits");

    a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=>
            strings_found == COUNT_BITS'($past(strings_found) + 1'b1))
        else $error("hit count not consecutive inside a run");

endmodule

bind lattice_string_plaquette_detector lspd_checker u_lspd_checker (
    .clk(clk),
    .rst_n(rst_n),
    .out_valid(hit_out.valid),
    .out_ready(hit_out.ready),
    .kind(hit_out.plaquette_kind),
    .strings_found(hit_out.strings_found),
    .last_of_run(hit_out.last_of_run)
);

FILE: tb/lspd_hit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lspd_hit_checker
// Watches the config port and both channels, predicts the string hits of
// every sample transfer and compares each hit transfer with the oldest one.
// ----------------------------------------------------------------------------
module lspd_hit_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lspd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lspd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    lspd_sample_if                              smp,
    lspd_hit_if                                 hit,
    output int                                  error_count,
    output int                                  hits_pending
);
    import lspd_pkg::*;

    localparam int RING_DEPTH = 64 * 64 + 64 + 1;

    typedef struct {
        logic [KIND_BITS-1:0]   kind;
        logic [ANCHOR_BITS-1:0] ax;
        logic [ANCHOR_BITS-1:0] ay;
        logic [ZANCH_BITS-1:0]  az;
        logic                   neg;
        logic [COUNT_BITS-1:0]  count;
        logic                   last;
    } string_hit_t;

    typedef struct {
        logic signed [15:0] re;
        logic signed [15:0] im;
    } field_t;

    string_hit_t expected_hits[$];
    field_t      ring[RING_DEPTH];
    int          ring_ptr;
    int          side, depth, col, row, plane;
    logic [COUNT_BITS-1:0] strings_seen;

    assign hits_pending = expected_hits.size();

    function automatic field_t past(int off);
        return ring[(ring_ptr + RING_DEPTH - off) % RING_DEPTH];
    endfunction

    function automatic int crossing(field_t a, field_t b);
        longint lhs, rhs;
        lhs = longint'(a.im) * longint'(b.re);
        rhs = longint'(a.re) * longint'(b.im);
        if ((a.im > 0) == (b.im > 0))
            return 0;
        return (lhs > rhs) ? 1 : -1;
    endfunction

    function automatic int circulation(field_t a, field_t b, field_t c, field_t d);
        return crossing(a, b) + crossing(b, c) + crossing(c, d) + crossing(d, a);
    endfunction

    task automatic add_hit(int w, logic [KIND_BITS-1:0] kind, int ax, int ay, int az);
        string_hit_t h;
        if (w != 2 && w != -2)
            return;
        strings_seen = strings_seen + 1'b1;
        h.kind  = kind;
        h.ax    = ANCHOR_BITS'(ax);
        h.ay    = ANCHOR_BITS'(ay);
        h.az    = ZANCH_BITS'(az);
        h.neg   = (w < 0);
        h.count = strings_seen;
        h.last  = 1'b0;
        expected_hits.push_back(h);
    endtask

    task automatic predict(field_t cur);
        int sq, before_n;
        sq = side * side;
        before_n = expected_hits.size();
        if (col >= 1 && row >= 1 && plane < depth)
            add_hit(circulation(past(side + 1), past(side), cur, past(1)),
                    KIND_XY, col - 1, row - 1, plane);
        if (row >= 1 && plane >= 1 && col + 2 <= side)
            add_hit(circulation(past(sq + side), past(sq), cur, past(side)),
                    KIND_YZ, col, row - 1, plane - 1);
        if (col >= 1 && plane >= 1 && row + 2 <= side)
            add_hit(circulation(past(sq + 1), past(1), cur, past(sq)),
                    KIND_XZ, col - 1, row, plane - 1);
        if (expected_hits.size() > before_n)
            expected_hits[$].last = 1'b1;
        ring[ring_ptr] = cur;
        ring_ptr = (ring_ptr + 1) % RING_DEPTH;
        if (col + 1 < side)
            col++;
        else begin
            col = 0;
            if (row + 1 < side)
                row++;
            else begin
                row = 0;
                if (plane < depth)
                    plane++;
                else
                begin
                    plane = 0;
                    strings_seen = '0;
                end
            end
        end
    endtask

    task automatic compare(string_hit_t e);
        if (hit.plaquette_kind !== e.kind)
        begin
            $error("plaquette_kind expected %0d got %0d", e.kind, hit.plaquette_kind);
            error_count++;
        end
        if (hit.anchor_x !== e.ax)
        begin
            $error("anchor_x expected %0d got %0d", e.ax, hit.anchor_x);
            error_count++;
        end
        if (hit.anchor_y !== e.ay)
        begin
            $error("anchor_y expected %0d got %0d", e.ay, hit.anchor_y);
            error_count++;
        end
        if (hit.anchor_z !== e.az)
        begin
            $error("anchor_z expected %0d got %0d", e.az, hit.anchor_z);
            error_count++;
        end
        if (hit.winding_negative !== e.neg)
        begin
            $error("winding_negative expected %0d got %0d", e.neg, hit.winding_negative);
            error_count++;
        end
        if (hit.strings_found !== e.count)
        begin
            $error("strings_found expected %0d got %0d", e.count, hit.strings_found);
            error_count++;
        end
        if (hit.last_of_run !== e.last)
        begin
            $error("last_of_run expected %0d got %0d", e.last, hit.last_of_run);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        field_t cur;
        int v;
        if (!rst_n)
        begin
            side = SIDE_RESET_VALUE;
            depth = DEPTH_RESET_VALUE;
            col = 0;
            row = 0;
            plane = 0;
            strings_seen = '0;
            ring_ptr = 0;
            error_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_SIDE_LENGTH)
                begin
                    v = int'(cfg_data) & 127;
                    side = (v < SIDE_MIN) ? SIDE_MIN : (v > 64 ? 64 : v);
                end
                else
                begin
                    v = int'(cfg_data);
                    depth = (v < DEPTH_MIN) ? DEPTH_MIN : (v > 1024 ? 1024 : v);
                end
                col = 0;
                row = 0;
                plane = 0;
                strings_seen = '0;
            end
            if (smp.valid && smp.ready)
            begin
                cur.re = smp.sample_real;
                cur.im = smp.sample_imag;
                predict(cur);
            end
            if (hit.valid && hit.ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    $error("hit transfer with no hit expected");
                    error_count++;
                end
                else
                    compare(expected_hits.pop_front());
            end
        end
    end

endmodule

FILE: tb/lattice_string_plaquette_detector_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lattice_string_plaquette_detector_tb
// Streams directed and random field volumes through the string detector over
// several lattice sizes, with random gaps on both channels and one long hold
// of the hit receiver; a checker beside the block compares every hit.
// ----------------------------------------------------------------------------
module lattice_string_plaquette_detector_tb;
    import lspd_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    int   error_count, hits_pending;
    bit   steady = 1'b0;
    bit   hold_request = 1'b0;
    bit   hold_taken = 1'b0;

    lspd_sample_if #(.SAMPLE_BITS(16)) smp_if ();
    lspd_hit_if                        hit_if ();

    lattice_string_plaquette_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample_in (smp_if),
        .hit_out   (hit_if)
    );

    lspd_hit_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .smp          (smp_if),
        .hit          (hit_if),
        .error_count  (error_count),
        .hits_pending (hits_pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // hit receiver with random stalls and one long hold
    initial
    begin
        hit_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_taken)
            begin
                hit_if.ready <= 1'b0;
                hold_taken = 1'b1;
                repeat (300) @(posedge clk);
            end
            else
                hit_if.ready <= steady || ($urandom_range(99) >= 6);
        end
    end

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_BITS'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (hits_pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im);
        if (!steady && $urandom_range(99) < 6)
        begin
            smp_if.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        smp_if.valid       <= 1'b1;
        smp_if.sample_real <= re;
        smp_if.sample_imag <= im;
        @(posedge clk);
        while (!smp_if.ready)
            @(posedge clk);
    endtask

    task automatic send_random();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            send_sample(16'($urandom), 16'($urandom));
        else if (pick < 85)
            send_sample(16'($urandom_range(6) - 3), 16'($urandom_range(6) - 3));
        else
            send_sample($urandom_range(1) ? 16'sh7fff : 16'sh8000,
                        $urandom_range(1) ? 16'sh7fff : 16'sh8000);
    endtask

    task automatic run_phase(int side_raw, int depth_raw, int count);
        smp_if.valid <= 1'b0;
        drain();
        write_reg(REG_SIDE_LENGTH, side_raw);
        write_reg(REG_DEPTH_PLANES, depth_raw);
        repeat (count) send_random();
    endtask

    initial
    begin
        cfg_we             <= 1'b0;
        cfg_index          <= REG_SIDE_LENGTH;
        cfg_data           <= '0;
        smp_if.valid       <= 1'b0;
        smp_if.sample_real <= '0;
        smp_if.sample_imag <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: 2x2 lattice, one anchor plane, saturating writes
        write_reg(REG_SIDE_LENGTH, 1);
        write_reg(REG_DEPTH_PLANES, 0);
        send_sample(16'sh7fff, 16'sh7fff);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd1, 16'sd0);
        send_sample(-16'sd1, -16'sd1);
        send_sample(16'sd0, 16'sd1);
        // rotating phase, both senses
        send_sample(16'sd100, 16'sd10);
        send_sample(-16'sd10, 16'sd100);
        send_sample(16'sd10, -16'sd100);
        send_sample(-16'sd100, -16'sd10);
        send_sample(16'sd100, 16'sd10);
        send_sample(16'sd10, -16'sd100);
        send_sample(-16'sd10, 16'sd100);
        send_sample(-16'sd100, -16'sd10);
        send_sample(16'sd100, 16'sd10);
        send_sample(-16'sd10, 16'sd100);
        send_sample(16'sd10, -16'sd100);
        send_sample(-16'sd100, -16'sd10);
        send_sample(16'sd0, -16'sd1);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sh7fff, 16'sd0);
        send_sample(16'sh8000, 16'sd0);

        // random phases over several lattice sizes
        run_phase(3, 2, 60);
        run_phase(4, 3, 50);
        hold_request = 1'b1;
        repeat (30) send_random();
        steady = 1'b1;
        repeat (50) send_random();
        steady = 1'b0;
        run_phase(2, 5, 60);
        run_phase(5, 1, 50);
        run_phase(127, 1, 70);
        run_phase(2, 2047, 20);

        smp_if.valid <= 1'b0;
        while (hits_pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

FILE: filelist.f
hdl/lspd_pkg.sv
hdl/lspd_sample_if.sv
hdl/lspd_hit_if.sv
hdl/lspd_ram.sv
hdl/lspd_front.sv
hdl/lspd_queue.sv
hdl/lspd_back.sv
hdl/lattice_string_plaquette_detector.sv
hdl/lspd_checker.sv
tb/lspd_hit_checker.sv
tb/lattice_string_plaquette_detector_tb.sv
